// ===== sv/bbt_pkg.sv =====
// ---------------------------------------------------------------------------
// bbt_pkg: constants for black-body temperature to RGB
// Locus polynomial coefficients (u scaled 1e15, v scaled 1e16) and the
// folded XYZ to linear RGB matrix terms.
// ---------------------------------------------------------------------------
package bbt_pkg;

	localparam int UV_BITS = 32;
	localparam int WIDE    = 64;

	localparam logic [63:0] NU_C0 = 64'd860117757000000;
	localparam logic [39:0] NU_C1 = 40'd154118254000;
	localparam logic [31:0] NU_C2 = 32'd128641212;
	localparam logic [63:0] DU_C0 = 64'd1000000000000000;
	localparam logic [39:0] DU_C1 = 40'd842420235000;
	localparam logic [31:0] DU_C2 = 32'd708145163;
	localparam logic [63:0] NV_C0 = 64'd3173987260000000;
	localparam logic [39:0] NV_C1 = 40'd422806245000;
	localparam logic [31:0] NV_C2 = 32'd420481691;
	localparam logic [63:0] DV_C0 = 64'd10000000000000000;
	localparam logic [39:0] DV_C1 = 40'd289741816000;
	localparam logic [31:0] DV_C2 = 32'd1614560530;

	// rgb = A*u + B*v + C, from X' = 3u, Y' = 2v, Z' = 4 - u - 10v
	localparam logic signed [28:0] MAT_A [3] = '{29'sd102198940, -29'sd29493540, -29'sd8902950};
	localparam logic signed [28:0] MAT_B [3] = '{29'sd19110370, 29'sd33364616, -29'sd109803038};
	localparam logic signed [63:0] MAT_C [3] = '{
		-64'sd4985314 <<< 34, 64'sd415560 <<< 34, 64'sd10572252 <<< 34};

endpackage

// ===== sv/bbt_div.sv =====
// ---------------------------------------------------------------------------
// bbt_div: pipelined restoring fraction divider
// One quotient bit per stage; quo = floor(num * 2^QW / den), zero when
// num >= den or den is zero. A sideband word travels with each item.
// ---------------------------------------------------------------------------
module bbt_div #(
	parameter int NW = 64,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	input  logic [SW-1:0] side,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic [NW-1:0] rem_s  [QW+1];
	logic [NW-1:0] den_s  [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];
	logic          kill_s [QW+1];

	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side;
	assign kill_s[0] = (den == '0) || (num >= den);

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [NW:0] sh;
		logic        ge;
		assign sh = {rem_s[k], 1'b0};
		assign ge = sh >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
				kill_s[k+1] <= 1'b0;
			end else if (en) begin
				side_s[k+1] <= side_s[k];
				kill_s[k+1] <= kill_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? NW'(sh - {1'b0, den_s[k]}) : sh[NW-1:0];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
			end
		end
	end

	assign quo      = kill_s[QW] ? '0 : quo_s[QW];
	assign side_out = side_s[QW];

endmodule

// ===== sv/blackbody_temp_to_rgb.sv =====
// ---------------------------------------------------------------------------
// blackbody_temp_to_rgb: color temperature to normalized linear RGB
// Usage:
//   Slave channel carries one temperature in kelvin per transfer (16-bit
//   unsigned). Master channel returns one transfer per input with red,
//   green and blue as signed Q1.FRACTION_BITS, the largest channel at 1.0.
//   Throughput: one transfer per cycle while the receiver accepts. The path
//   from input transfer to master tvalid runs through two polynomial stages,
//   a 32-stage u/v divider, four matrix/max/magnitude stages, a
//   FRACTION_BITS-stage normalize divider and one output register.
//   The whole pipeline advances together; when the receiver holds tready
//   low with a result waiting, all stages hold and s_axis_tready drops.
//   Nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
// ---------------------------------------------------------------------------
module blackbody_temp_to_rgb #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // temperature_k
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// red, green, blue (each FRACTION_BITS+2), zero pad
	output logic [(((3 * (FRACTION_BITS + 2)) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int OW = FRACTION_BITS + 2;
	localparam int TW = ((3 * OW + 7) / 8) * 8;
	localparam int W  = bbt_pkg::WIDE;
	localparam int UB = bbt_pkg::UV_BITS;

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: t squared and linear terms
	logic          v_s1;
	logic [31:0]   tt_s1;
	logic [W-1:0]  nul_s1, dul_s1, nvl_s1, dvl_s1;
	logic [55:0]   pnu1, pdu1, pnv1, pdv1;

	assign pnu1 = bbt_pkg::NU_C1 * s_axis_tdata;
	assign pdu1 = bbt_pkg::DU_C1 * s_axis_tdata;
	assign pnv1 = bbt_pkg::NV_C1 * s_axis_tdata;
	assign pdv1 = bbt_pkg::DV_C1 * s_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tt_s1  <= s_axis_tdata * s_axis_tdata;
			nul_s1 <= bbt_pkg::NU_C0 + W'(pnu1);
			dul_s1 <= bbt_pkg::DU_C0 + W'(pdu1);
			nvl_s1 <= bbt_pkg::NV_C0 + W'(pnv1);
			dvl_s1 <= bbt_pkg::DV_C0 - W'(pdv1);
		end
	end

	// stage 2: quadratic terms
	logic         v_s2;
	logic [W-1:0] nu_s2, du_s2, nv_s2, dv_s2;
	logic [63:0]  pnu2, pdu2, pnv2, pdv2;

	assign pnu2 = bbt_pkg::NU_C2 * tt_s1;
	assign pdu2 = bbt_pkg::DU_C2 * tt_s1;
	assign pnv2 = bbt_pkg::NV_C2 * tt_s1;
	assign pdv2 = bbt_pkg::DV_C2 * tt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nu_s2 <= nul_s1 + pnu2;
			du_s2 <= dul_s1 + pdu2;
			nv_s2 <= nvl_s1 + pnv2;
			dv_s2 <= dvl_s1 + pdv2;
		end
	end

	// u and v dividers
	logic [UB-1:0] u_d, v_d;
	logic          vu_d, vv_d;

	bbt_div #(.NW(W), .QW(UB), .SW(1)) u_div_u (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(nu_s2), .den(du_s2), .side(v_s2),
		.quo(u_d), .side_out(vu_d)
	);

	bbt_div #(.NW(W), .QW(UB), .SW(1)) u_div_v (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(nv_s2), .den(dv_s2), .side(v_s2),
		.quo(v_d), .side_out(vv_d)
	);

	// stage 3: matrix products
	logic                v_s3;
	logic signed [61:0]  pa_s3 [3];
	logic signed [61:0]  pb_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= vu_d && vv_d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pa_s3[i] <= bbt_pkg::MAT_A[i] * $signed({1'b0, u_d});
				pb_s3[i] <= bbt_pkg::MAT_B[i] * $signed({1'b0, v_d});
			end
		end
	end

	// stage 4: channel sums
	logic               v_s4;
	logic signed [W-1:0] rgb_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				rgb_s4[i] <= W'(pa_s3[i]) + W'(pb_s3[i]) + bbt_pkg::MAT_C[i];
		end
	end

	// stage 5: maximum
	logic               v_s5;
	logic signed [W-1:0] rgb_s5 [3];
	logic signed [W-1:0] mx_s5;
	logic signed [W-1:0] mx01;

	assign mx01 = (rgb_s4[1] > rgb_s4[0]) ? rgb_s4[1] : rgb_s4[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s5 <= rgb_s4;
			mx_s5  <= (rgb_s4[2] > mx01) ? rgb_s4[2] : mx01;
		end
	end

	// stage 6: magnitudes and signs
	logic         v_s6, zero_s6;
	logic [W-1:0] a_s6 [3];
	logic [W-1:0] b_s6;
	logic [2:0]   neg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				a_s6[i]   <= rgb_s5[i][W-1] ? W'(-rgb_s5[i]) : W'(rgb_s5[i]);
				neg_s6[i] <= rgb_s5[i][W-1] ^ mx_s5[W-1];
			end
			b_s6    <= mx_s5[W-1] ? W'(-mx_s5) : W'(mx_s5);
			zero_s6 <= (mx_s5 == '0);
		end
	end

	// normalize dividers; side = {valid, zero, saturate, negate}
	logic [FRACTION_BITS-1:0] q_d    [3];
	logic [3:0]               side_d [3];

	for (genvar i = 0; i < 3; i++) begin : g_norm
		bbt_div #(.NW(W), .QW(FRACTION_BITS), .SW(4)) u_div_n (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.num(a_s6[i]), .den(b_s6),
			.side({v_s6, zero_s6, a_s6[i] >= b_s6, neg_s6[i]}),
			.quo(q_d[i]), .side_out(side_d[i])
		);
	end

	// output register
	logic [OW-1:0] res [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (side_d[i][2])
				res[i] = '0;
			else if (side_d[i][1])
				res[i] = side_d[i][0] ? OW'(-(OW'(1) << FRACTION_BITS))
				                      : (OW'(1) << FRACTION_BITS);
			else
				res[i] = side_d[i][0] ? OW'(-{2'b00, q_d[i]}) : {2'b00, q_d[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (adv) m_axis_tvalid <= side_d[0][3];
	end

	always_ff @(posedge clk) begin
		if (adv)
			m_axis_tdata <= TW'({res[2], res[1], res[0]});
	end

endmodule

// ===== sim/blackbody_temp_to_rgb_checker.sv =====
// ---------------------------------------------------------------------------
// blackbody_temp_to_rgb_checker: result predictor and comparator
// Watches both stream channels. Every input transfer is converted to its
// expected normalized RGB triple, and every output transfer is compared
// field by field with the oldest triple still waiting.
// ---------------------------------------------------------------------------
module blackbody_temp_to_rgb_checker (
	input  logic        clk,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // temperature_k
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,  // red, green, blue (18 each), zero pad
	output int          fail_count,
	output int          pending,
	output int          result_count
);

	localparam int FRAC = 16;

	typedef struct packed {
		logic signed [17:0] red;
		logic signed [17:0] green;
		logic signed [17:0] blue;
	} rgb_t;

	rgb_t rgb_queue[$];

	function automatic logic [63:0] fixed_quotient(logic [63:0] num, logic [63:0] den, int bits);
		logic [63:0] rem;
		logic [63:0] q;
		rem = num;
		q = '0;
		if (den == 0 || num >= den)
			return '0;
		for (int i = 0; i < bits; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] abs64(logic signed [63:0] x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic signed [63:0] ratio_to_max(logic signed [63:0] chan,
			logic signed [63:0] mx);
		logic [63:0] a;
		logic [63:0] b;
		logic signed [63:0] q;
		a = abs64(chan);
		b = abs64(mx);
		if (a >= b)
			q = 64'sd1 <<< FRAC;
		else
			q = $signed(fixed_quotient(a, b, FRAC));
		if ((chan < 0) != (mx < 0))
			q = -q;
		return q;
	endfunction

	function automatic rgb_t locus_rgb(logic [15:0] kelvin);
		logic [63:0] t;
		logic [63:0] tt;
		logic [63:0] nu, du, nv, dv, u, v;
		logic signed [63:0] xyz[3];
		logic signed [63:0] lin[3];
		logic signed [63:0] mx;
		logic signed [63:0] norm[3];
		logic signed [63:0] m[3][3];
		rgb_t res;
		m = '{'{64'sd32404542, -64'sd15371385, -64'sd4985314},
			'{-64'sd9692660, 64'sd18760108, 64'sd415560},
			'{64'sd556434, -64'sd2040259, 64'sd10572252}};
		t = 64'(kelvin);
		tt = t * t;
		nu = 64'd860117757000000 + 64'd154118254000 * t + 64'd128641212 * tt;
		du = 64'd1000000000000000 + 64'd842420235000 * t + 64'd708145163 * tt;
		nv = 64'd3173987260000000 + 64'd422806245000 * t + 64'd420481691 * tt;
		dv = 64'd10000000000000000 + 64'd1614560530 * tt - 64'd289741816000 * t;
		u = fixed_quotient(nu, du, 32);
		v = fixed_quotient(nv, dv, 32);
		xyz[0] = 3 * $signed(u);
		xyz[1] = 2 * $signed(v);
		xyz[2] = (64'sd4 <<< 32) - $signed(u) - 10 * $signed(v);
		for (int i = 0; i < 3; i++) begin
			lin[i] = 0;
			for (int j = 0; j < 3; j++)
				lin[i] = lin[i] + m[i][j] * xyz[j];
		end
		mx = lin[0];
		if (lin[1] > mx)
			mx = lin[1];
		if (lin[2] > mx)
			mx = lin[2];
		for (int i = 0; i < 3; i++)
			norm[i] = (mx == 0) ? 64'sd0 : ratio_to_max(lin[i], mx);
		res.red = norm[0][17:0];
		res.green = norm[1][17:0];
		res.blue = norm[2][17:0];
		return res;
	endfunction

	initial begin
		fail_count = 0;
		result_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		rgb_t want;
		logic signed [17:0] r, g, b;
		if (s_axis_tvalid && s_axis_tready)
			rgb_queue.push_back(locus_rgb(s_axis_tdata));
		if (m_axis_tvalid && m_axis_tready) begin
			r = m_axis_tdata[17:0];
			g = m_axis_tdata[35:18];
			b = m_axis_tdata[53:36];
			result_count++;
			if (rgb_queue.size() == 0) begin
				$error("unexpected result transfer red=%0d green=%0d blue=%0d", r, g, b);
				fail_count++;
			end else begin
				want = rgb_queue.pop_front();
				if (r !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, r);
					fail_count++;
				end
				if (g !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, g);
					fail_count++;
				end
				if (b !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, b);
					fail_count++;
				end
			end
		end
		pending = rgb_queue.size();
	end

endmodule

// ===== sim/blackbody_temp_to_rgb_test.sv =====
// ---------------------------------------------------------------------------
// blackbody_temp_to_rgb_test: stream testbench for the temperature converter
// Sends directed and random kelvin values with random gaps, stalls the
// result side at random and once for a long stretch, and reports the
// verdict from the checker's failure and pending counts.
// ---------------------------------------------------------------------------
module blackbody_temp_to_rgb_test;

	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT  = 300000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;

	int  fail_count;
	int  pending;
	int  result_count;
	int  cycle;
	int  sent;
	bit  s_taken;

	blackbody_temp_to_rgb dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	blackbody_temp_to_rgb_checker checker_inst (
		.clk(clk),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count),
		.pending(pending),
		.result_count(result_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		s_taken <= s_axis_tvalid && s_axis_tready;
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls, a calm stretch, and one long hold-off
	initial begin : receiver
		int hold;
		hold = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cycle == 1200)
				hold = 400;
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (cycle > 1700 && cycle < 3000)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= ($urandom_range(99) >= 20);
		end
	end

	task automatic send_kelvin(logic [15:0] kelvin, bit calm);
		if (!calm) begin
			while ($urandom_range(99) < 20) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= kelvin;
		@(negedge clk);
		while (!s_taken)
			@(negedge clk);
		sent++;
	endtask

	initial begin : stimulus
		logic [15:0] directed[$];
		logic [15:0] k;
		int sel;
		cycle = 0;
		sent = 0;
		s_taken = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed = '{16'd0, 16'd1, 16'd2, 16'd65535, 16'd65534, 16'd32768, 16'd32767,
			16'd1000, 16'd1667, 16'd2000, 16'd2700, 16'd4000, 16'd5000, 16'd6500,
			16'd6504, 16'd10000, 16'd15000, 16'd25000, 16'd40000, 16'h5555, 16'haaaa,
			16'h00ff, 16'hff00};
		foreach (directed[i])
			send_kelvin(directed[i], 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = int'($urandom_range(99));
			if (sel < 70)
				k = 16'($urandom_range(25000, 1000));
			else if (sel < 80)
				k = 16'($urandom_range(999, 0));
			else
				k = 16'($urandom);
			send_kelvin(k, n > 400 && n < 700);
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);

		$display("%0d temperatures sent, %0d results checked, including extremes,",
			sent, result_count);
		$display("random gaps on both sides and a long output stall");
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
